FILE: src/lkx_pkg.sv
// Shared types and constants for the keyed XOR-chain byte cipher.
// Used by every module of the block; depends on nothing.
package lkx_pkg;

  // Park-Miller minimal-standard generator.
  localparam logic [14:0] GEN_MUL  = 15'd16807;
  localparam logic [30:0] GEN_MOD  = 31'h7fffffff;
  localparam logic [30:0] GEN_INIT = 31'h000a2c2a;

  // Defaults for the top-level parameters.
  localparam int DEF_TABLE_DEPTH = 512;
  localparam int DEF_ENTRY_SCALE = 256;

  // Queue between the front and the back.
  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);

  typedef struct packed {
    logic       func;
    logic [7:0] data;
    logic       eom;
  } item_t;

endpackage

FILE: src/lcg_keyed_xor_chain_cipher_top.sv
// Top level of the keyed XOR-chain byte cipher: key table generator, front
// end, queue and back end. Depends on lkx_pkg and the lkx_* modules.
//
//   channel  | handshake                    | payload
//   ---------+------------------------------+-------------------------------
//   input    | valid / stall (block drives) | func, data_in, end_of_message
//   result   | result_valid / result_stall  | data_out, last_out
//
// One word per clock is sustained while result_stall is low; a word goes
// through the front register, the queue and the table read stage to the
// result register. After reset the generator fills the key table (states
// multiply, reduce, scale, write per entry); stall stays high until done.
// A stalled result holds the read stage, then the queue fills, then stall rises.
module lcg_keyed_xor_chain_cipher_top #(
  parameter int TABLE_DEPTH = lkx_pkg::DEF_TABLE_DEPTH,
  parameter int ENTRY_SCALE = lkx_pkg::DEF_ENTRY_SCALE
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       valid,
  output logic       stall,
  input  logic       func,
  input  logic [7:0] data_in,
  input  logic       end_of_message,
  output logic       result_valid,
  input  logic       result_stall,
  output logic [7:0] data_out,
  output logic       last_out
);
  import lkx_pkg::*;

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int QW = $bits(item_t) + 2 * AW;

  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [7:0]    wr_data;
  logic          tbl_ready;
  logic          push;
  logic [QW-1:0] push_data;
  logic          q_full;
  logic          pop;
  logic [QW-1:0] pop_data;
  logic          q_empty;

  lkx_gen #(
    .TABLE_DEPTH(TABLE_DEPTH),
    .ENTRY_SCALE(ENTRY_SCALE)
  ) u_gen (
    .clk    (clk),
    .rst    (rst),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .ready  (tbl_ready)
  );

  lkx_front #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .valid         (valid),
    .stall         (stall),
    .func          (func),
    .data_in       (data_in),
    .end_of_message(end_of_message),
    .tbl_ready     (tbl_ready),
    .push          (push),
    .push_data     (push_data),
    .q_full        (q_full)
  );

  lkx_queue #(
    .WIDTH(QW)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_data(push_data),
    .full     (q_full),
    .pop      (pop),
    .pop_data (pop_data),
    .empty    (q_empty)
  );

  lkx_back #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .wr_en       (wr_en),
    .wr_addr     (wr_addr),
    .wr_data     (wr_data),
    .q_empty     (q_empty),
    .q_data      (pop_data),
    .pop         (pop),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .data_out    (data_out),
    .last_out    (last_out)
  );

endmodule

FILE: src/lkx_gen.sv
// Key table generator: steps the Park-Miller generator once per entry and
// writes the scaled value, top entry first. Depends on lkx_pkg.
module lkx_gen #(
  parameter int TABLE_DEPTH = 512,
  parameter int ENTRY_SCALE = 256
) (
  input  logic                           clk,
  input  logic                           rst,
  output logic                           wr_en,
  output logic [$clog2(TABLE_DEPTH)-1:0] wr_addr,
  output logic [7:0]                     wr_data,
  output logic                           ready
);
  import lkx_pkg::*;

  localparam int AW  = $clog2(TABLE_DEPTH);
  localparam int CW  = $clog2(TABLE_DEPTH + 1);
  localparam int SBW = $clog2(ENTRY_SCALE + 1);
  localparam int SW  = 31 + SBW;
  localparam int PW  = 31 + 15;
  localparam logic [SBW-1:0] SCALE_V = SBW'(ENTRY_SCALE);

  localparam logic [2:0] ST_MUL  = 3'd0;
  localparam logic [2:0] ST_RED  = 3'd1;
  localparam logic [2:0] ST_SCL  = 3'd2;
  localparam logic [2:0] ST_WR   = 3'd3;
  localparam logic [2:0] ST_DONE = 3'd4;

  logic [2:0]    state;
  logic [CW-1:0] cnt;
  logic [30:0]   seed;
  logic [PW-1:0] prod;
  logic [SW-1:0] scaled;

  logic [31:0]    red_sum;
  logic [30:0]    seed_next;
  logic [SBW-1:0] hi;
  logic [31:0]    hl_sum;
  logic [SBW-1:0] quot;

  // Reduction modulo 2^31-1: fold the high part onto the low part.
  always_comb begin
    red_sum = {1'b0, prod[30:0]} + 32'(prod[PW-1:31]);
    if (red_sum >= {1'b0, GEN_MOD}) begin
      seed_next = 31'(red_sum - {1'b0, GEN_MOD});
    end else begin
      seed_next = red_sum[30:0];
    end
  end

  // floor(x / (2^31-1)) = h + ((h + l) >= 2^31-1), since the quotient is small.
  always_comb begin
    hi     = scaled[SW-1:31];
    hl_sum = {1'b0, scaled[30:0]} + 32'(hi);
    quot   = hi + SBW'(hl_sum >= {1'b0, GEN_MOD});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_MUL;
      cnt   <= CW'(TABLE_DEPTH);
      seed  <= GEN_INIT;
    end else begin
      case (state)
        ST_MUL: begin
          state <= ST_RED;
        end
        ST_RED: begin
          seed  <= seed_next;
          state <= ST_SCL;
        end
        ST_SCL: begin
          state <= ST_WR;
        end
        ST_WR: begin
          cnt   <= cnt - 1'b1;
          state <= (cnt == CW'(1)) ? ST_DONE : ST_MUL;
        end
        ST_DONE: begin
          state <= ST_DONE;
        end
        default: begin
          state <= ST_DONE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    prod   <= PW'(seed) * PW'(GEN_MUL);
    scaled <= SW'(seed) * SW'(SCALE_V);
  end

  assign wr_en   = (state == ST_WR);
  assign wr_addr = AW'(cnt - 1'b1);
  assign wr_data = 8'(quot);
  assign ready   = (state == ST_DONE);

  a_ready_holds: assert property (@(posedge clk) disable iff (rst) ready |=> ready)
    else $error("table ready dropped after the fill finished");
  a_no_write_when_ready: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> (!ready && cnt != '0))
    else $error("table write outside the fill");

endmodule

FILE: src/lkx_front.sv
// Front end: accepts words once the key table is ready and tags each with
// its two key table positions. Depends on lkx_pkg.
module lkx_front #(
  parameter int TABLE_DEPTH = 512
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               valid,
  output logic                               stall,
  input  logic                               func,
  input  logic [7:0]                         data_in,
  input  logic                               end_of_message,
  input  logic                               tbl_ready,
  output logic                               push,
  output logic [$bits(lkx_pkg::item_t)+2*$clog2(TABLE_DEPTH)-1:0] push_data,
  input  logic                               q_full
);
  import lkx_pkg::*;

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam logic [AW:0]   DEPTH_V = (AW + 1)'(TABLE_DEPTH);
  localparam logic [AW-1:0] LAST_V  = AW'(TABLE_DEPTH - 1);

  logic          held;
  item_t         item;
  logic [AW-1:0] k0;
  logic [AW-1:0] k1;
  logic [AW-1:0] pos;
  logic [AW-1:0] pos_next;
  logic [AW:0]   pos_sum;
  logic          take;

  assign stall = !tbl_ready || (held && q_full);
  assign take  = valid && !stall;
  assign push  = held && !q_full;

  always_comb begin
    pos_sum = {1'b0, pos} + (AW + 1)'(2);
    if (pos_sum >= DEPTH_V) begin
      pos_sum = pos_sum - DEPTH_V;
    end
    pos_next = end_of_message ? '0 : pos_sum[AW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
      pos  <= '0;
    end else begin
      if (take) begin
        held <= 1'b1;
        pos  <= pos_next;
      end else if (push) begin
        held <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      item.func <= func;
      item.data <= data_in;
      item.eom  <= end_of_message;
      k0        <= pos;
      k1        <= (pos == LAST_V) ? '0 : pos + 1'b1;
    end
  end

  assign push_data = {item, k0, k1};

  a_key_in_range: assert property (@(posedge clk) disable iff (rst)
    held |-> ({1'b0, k0} < DEPTH_V && {1'b0, k1} < DEPTH_V))
    else $error("key position beyond the table");

endmodule

FILE: src/lkx_queue.sv
// Short register queue between the front and the back.
// Depends on lkx_pkg for its depth.
module lkx_queue #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             empty
);
  import lkx_pkg::*;

  logic [WIDTH-1:0] slots [QDEPTH];
  logic [QAW-1:0]   wr_ptr;
  logic [QAW-1:0]   rd_ptr;
  logic [QAW:0]     count;

  assign full     = (count == (QAW + 1)'(QDEPTH));
  assign empty    = (count == '0);
  assign pop_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    !(push && full) && !(pop && empty))
    else $error("queue pushed when full or popped when empty");

endmodule

FILE: src/lkx_back.sv
// Back end: holds the key table, reads both key bytes for a word, applies
// the XOR chain and keeps the result in an output register. Depends on lkx_pkg.
module lkx_back #(
  parameter int TABLE_DEPTH = 512
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           wr_en,
  input  logic [$clog2(TABLE_DEPTH)-1:0] wr_addr,
  input  logic [7:0]                     wr_data,
  input  logic                           q_empty,
  input  logic [$bits(lkx_pkg::item_t)+2*$clog2(TABLE_DEPTH)-1:0] q_data,
  output logic                           pop,
  output logic                           result_valid,
  input  logic                           result_stall,
  output logic [7:0]                     data_out,
  output logic                           last_out
);
  import lkx_pkg::*;

  localparam int AW = $clog2(TABLE_DEPTH);

  logic [7:0] key_mem [TABLE_DEPTH];

  item_t         q_item;
  logic [AW-1:0] q_k0;
  logic [AW-1:0] q_k1;

  logic       s1_valid;
  item_t      s1_item;
  logic [7:0] key0;
  logic [7:0] key1;
  logic [7:0] chain;
  logic [7:0] dout;
  logic [7:0] cipher;
  logic       adv;

  assign {q_item, q_k0, q_k1} = q_data;

  // The read stage moves on whenever the output register is free or taken.
  assign adv = s1_valid && (!result_valid || !result_stall);
  assign pop = !q_empty && (!s1_valid || adv);

  assign dout   = s1_item.data ^ key0 ^ chain;
  assign cipher = s1_item.func ? s1_item.data : dout;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      key_mem[wr_addr] <= wr_data;
    end
    if (pop) begin
      key0    <= key_mem[q_k0];
      key1    <= key_mem[q_k1];
      s1_item <= q_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid     <= 1'b0;
      result_valid <= 1'b0;
      chain        <= '0;
    end else begin
      if (pop) begin
        s1_valid <= 1'b1;
      end else if (adv) begin
        s1_valid <= 1'b0;
      end
      if (!result_valid || !result_stall) begin
        result_valid <= s1_valid;
      end
      if (adv) begin
        chain <= s1_item.eom ? 8'h00 : (cipher ^ key1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      data_out <= dout;
      last_out <= s1_item.eom;
    end
  end

  a_chain_clear: assert property (@(posedge clk) disable iff (rst)
    (adv && s1_item.eom) |=> (chain == 8'h00))
    else $error("chain byte not cleared after end of message");

endmodule
